// ===== hw/rtl/cotp_pkg.sv =====
package cotp_pkg;

    // default depth of the option payload store
    localparam int unsigned MAX_OPTION_PAYLOAD_DEF = 22;

    // payload bytes that the field decode looks at (largest fixed option size)
    localparam int unsigned DEC_BYTES = 22;

    // result queue depth and its index widths
    localparam int unsigned RQ_DEPTH = 4;
    localparam int unsigned RQ_AW    = $clog2(RQ_DEPTH);
    localparam int unsigned RQ_CW    = $clog2(RQ_DEPTH + 1);

    // option type codes
    localparam logic [7:0] OPT_MTU   = 8'd1;
    localparam logic [7:0] OPT_FLUSH = 8'd2;
    localparam logic [7:0] OPT_QOS   = 8'd3;
    localparam logic [7:0] OPT_RFC   = 8'd4;
    localparam logic [7:0] OPT_FCS   = 8'd5;
    localparam logic [7:0] OPT_EFS   = 8'd6;
    localparam logic [7:0] OPT_EWS   = 8'd7;

    // fixed payload sizes of the known options
    localparam logic [7:0] SZ_MTU   = 8'd2;
    localparam logic [7:0] SZ_FLUSH = 8'd2;
    localparam logic [7:0] SZ_QOS   = 8'd22;
    localparam logic [7:0] SZ_RFC   = 8'd9;
    localparam logic [7:0] SZ_FCS   = 8'd1;
    localparam logic [7:0] SZ_EFS   = 8'd16;
    localparam logic [7:0] SZ_EWS   = 8'd2;

    typedef enum logic [1:0] {
        PH_TYPE = 2'd0,
        PH_LEN  = 2'd1,
        PH_DATA = 2'd2,
        PH_SKIP = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        EV_OPTION  = 2'd0,
        EV_UNKNOWN = 2'd1,
        EV_DONE    = 2'd2,
        EV_TRUNC   = 2'd3
    } t_event;

    typedef struct packed {
        logic [1:0]  event_res;
        logic [7:0]  raw_type;
        logic [7:0]  byte_a;
        logic [7:0]  byte_b;
        logic [7:0]  byte_c;
        logic [31:0] word_0;
        logic [31:0] word_1;
        logic [31:0] word_2;
        logic [31:0] word_3;
        logic [31:0] word_4;
        logic        run_last;
    } t_result;

    // up to two results per input byte: option or unknown first, end event second
    typedef struct packed {
        logic    prim_valid;
        logic    end_valid;
        t_result prim;
        t_result fin;
    } t_push;

    // zero means not a known option
    function automatic logic [7:0] fixed_size(input logic [7:0] t);
        logic [7:0] s;
        case (t)
            OPT_MTU:   s = SZ_MTU;
            OPT_FLUSH: s = SZ_FLUSH;
            OPT_QOS:   s = SZ_QOS;
            OPT_RFC:   s = SZ_RFC;
            OPT_FCS:   s = SZ_FCS;
            OPT_EFS:   s = SZ_EFS;
            OPT_EWS:   s = SZ_EWS;
            default:   s = 8'd0;
        endcase
        return s;
    endfunction

endpackage

// ===== hw/rtl/config_option_tlv_parser.sv =====
// results: those of a taken byte are registered into the result queue before they reach the master
// side; a second result from the same byte is written in the same cycle and follows the first
// throughput: one byte per cycle; the slave side stalls only while the 4-entry result queue
// has fewer than two free slots (the most one byte can produce)
// reset: i_rst_n synchronous, active low; clears the parse state and empties the queue,
// the payload store is not cleared
module config_option_tlv_parser #(
    parameter int unsigned MAX_OPTION_PAYLOAD = cotp_pkg::MAX_OPTION_PAYLOAD_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // byte stream in
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [7:0]   i_s_tdata,   // [7:0] data_byte
    input  logic         i_s_tlast,   // block_end
    // result stream out
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [191:0] o_m_tdata,   // raw_type, byte_a, byte_b, byte_c,
                                      // word_0, word_1, word_2, word_3, word_4
    output logic [1:0]   o_m_tuser,   // [1:0] event_res
    output logic         o_m_tlast    // run_last
);

    cotp_pkg::t_push   push;
    cotp_pkg::t_result head;
    logic              in_fire;
    logic              space;

    // a byte is taken whenever the queue can hold both possible results
    assign o_s_tready = space;
    assign in_fire    = i_s_tvalid && space;

    // parse state, payload store and field decode; results land straight in the queue
    cotp_parser #(
        .MAX_OPTION_PAYLOAD (MAX_OPTION_PAYLOAD)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (in_fire),
        .i_byte  (i_s_tdata),
        .i_end   (i_s_tlast),
        .o_push  (push)
    );

    // result queue decouples the two sides
    cotp_res_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (i_m_tready),
        .o_space (space),
        .o_valid (o_m_tvalid),
        .o_head  (head)
    );

    // pack the result word, first field lowest
    assign o_m_tdata = {head.word_4, head.word_3, head.word_2, head.word_1, head.word_0,
                        head.byte_c, head.byte_b, head.byte_a, head.raw_type};
    assign o_m_tuser = head.event_res;
    assign o_m_tlast = head.run_last;

endmodule

// ===== hw/rtl/cotp_parser.sv =====
module cotp_parser #(
    parameter int unsigned MAX_OPTION_PAYLOAD = cotp_pkg::MAX_OPTION_PAYLOAD_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_fire,
    input  logic [7:0]      i_byte,
    input  logic            i_end,
    output cotp_pkg::t_push o_push
);

    localparam int unsigned IDXW = $clog2(MAX_OPTION_PAYLOAD);

    cotp_pkg::t_phase r_phase, n_phase;
    logic [7:0] r_type, n_type;
    logic [7:0] r_len, n_len;
    logic [7:0] r_count, n_count;
    logic       r_discard, n_discard;

    logic [7:0] r_store [MAX_OPTION_PAYLOAD];
    logic       store_we;

    logic [7:0] m [cotp_pkg::DEC_BYTES];
    logic [7:0] sz;
    logic [7:0] cnt_inc;
    cotp_pkg::t_result opt_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= cotp_pkg::PH_TYPE;
            r_type    <= '0;
            r_len     <= '0;
            r_count   <= '0;
            r_discard <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_type    <= n_type;
            r_len     <= n_len;
            r_count   <= n_count;
            r_discard <= n_discard;
        end
    end

    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_store[r_count[IDXW-1:0]] <= i_byte;
        end
    end

    // store contents with the byte arriving now merged in
    always_comb begin
        for (int i = 0; i < int'(cotp_pkg::DEC_BYTES); i++) begin
            m[i] = (r_count == 8'(i)) ? i_byte : r_store[i];
        end
    end

    // little-endian field decode of a complete option
    always_comb begin
        opt_res           = '0;
        opt_res.event_res = cotp_pkg::EV_OPTION;
        opt_res.raw_type  = r_type;
        case (r_type)
            cotp_pkg::OPT_MTU, cotp_pkg::OPT_FLUSH, cotp_pkg::OPT_EWS: begin
                opt_res.word_0 = {16'd0, m[1], m[0]};
            end
            cotp_pkg::OPT_QOS: begin
                // first byte holds flags and is not reported
                opt_res.byte_a = m[1];
                opt_res.word_0 = {m[5], m[4], m[3], m[2]};
                opt_res.word_1 = {m[9], m[8], m[7], m[6]};
                opt_res.word_2 = {m[13], m[12], m[11], m[10]};
                opt_res.word_3 = {m[17], m[16], m[15], m[14]};
                opt_res.word_4 = {m[21], m[20], m[19], m[18]};
            end
            cotp_pkg::OPT_RFC: begin
                opt_res.byte_a = m[0];
                opt_res.byte_b = m[1];
                opt_res.byte_c = m[2];
                opt_res.word_0 = {16'd0, m[4], m[3]};
                opt_res.word_1 = {16'd0, m[6], m[5]};
                opt_res.word_2 = {16'd0, m[8], m[7]};
            end
            cotp_pkg::OPT_FCS: begin
                opt_res.byte_a = m[0];
            end
            cotp_pkg::OPT_EFS: begin
                opt_res.byte_a = m[0];
                opt_res.byte_b = m[1];
                opt_res.word_0 = {16'd0, m[3], m[2]};
                opt_res.word_1 = {m[7], m[6], m[5], m[4]};
                opt_res.word_2 = {m[11], m[10], m[9], m[8]};
                opt_res.word_3 = {m[15], m[14], m[13], m[12]};
            end
            default: begin
                opt_res.raw_type = r_type;
            end
        endcase
    end

    always_comb begin
        n_phase   = r_phase;
        n_type    = r_type;
        n_len     = r_len;
        n_count   = r_count;
        n_discard = r_discard;
        store_we  = 1'b0;
        sz        = cotp_pkg::fixed_size(r_type);
        cnt_inc   = r_count + 8'd1;
        o_push    = '0;

        if (i_fire) begin
            if (!r_discard) begin
                case (r_phase)
                    cotp_pkg::PH_TYPE: begin
                        n_type  = i_byte;
                        n_phase = cotp_pkg::PH_LEN;
                    end
                    cotp_pkg::PH_LEN: begin
                        n_len   = i_byte;
                        n_count = '0;
                        if (sz == 8'd0) begin
                            o_push.prim_valid         = 1'b1;
                            o_push.prim.event_res     = cotp_pkg::EV_UNKNOWN;
                            o_push.prim.raw_type      = r_type;
                            n_phase = (i_byte == 8'd0) ? cotp_pkg::PH_TYPE
                                                       : cotp_pkg::PH_SKIP;
                        end else if (i_byte != sz) begin
                            n_discard = 1'b1;
                        end else begin
                            n_phase = cotp_pkg::PH_DATA;
                        end
                    end
                    cotp_pkg::PH_DATA: begin
                        store_we = (r_count < 8'(MAX_OPTION_PAYLOAD));
                        n_count  = cnt_inc;
                        if (cnt_inc >= r_len) begin
                            o_push.prim_valid = 1'b1;
                            o_push.prim       = opt_res;
                            n_phase           = cotp_pkg::PH_TYPE;
                        end
                    end
                    default: begin
                        n_count = cnt_inc;
                        if (cnt_inc >= r_len) begin
                            n_phase = cotp_pkg::PH_TYPE;
                        end
                    end
                endcase
            end

            o_push.prim.run_last = !i_end;

            if (i_end) begin
                o_push.end_valid     = 1'b1;
                o_push.fin.event_res = (n_discard || n_phase != cotp_pkg::PH_TYPE)
                                       ? cotp_pkg::EV_TRUNC : cotp_pkg::EV_DONE;
                o_push.fin.run_last  = 1'b1;
                n_phase   = cotp_pkg::PH_TYPE;
                n_type    = '0;
                n_len     = '0;
                n_count   = '0;
                n_discard = 1'b0;
            end
        end
    end

endmodule

// ===== hw/rtl/cotp_res_queue.sv =====
module cotp_res_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cotp_pkg::t_push   i_push,
    input  logic              i_pop,
    output logic              o_space,
    output logic              o_valid,
    output cotp_pkg::t_result o_head
);

    localparam int unsigned AW = cotp_pkg::RQ_AW;
    localparam int unsigned CW = cotp_pkg::RQ_CW;

    cotp_pkg::t_result r_mem [cotp_pkg::RQ_DEPTH];
    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] nwr;
    logic          pop_ok;

    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd];
    // room for the two results one byte can produce
    assign o_space = (r_count <= CW'(cotp_pkg::RQ_DEPTH - 2));
    assign pop_ok  = i_pop && o_valid;

    always_comb begin
        nwr     = CW'(i_push.prim_valid) + CW'(i_push.end_valid);
        n_wr    = r_wr + AW'(nwr);
        n_rd    = r_rd + AW'(pop_ok);
        n_count = r_count + nwr - CW'(pop_ok);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.prim_valid) begin
            r_mem[r_wr] <= i_push.prim;
            if (i_push.end_valid) begin
                r_mem[r_wr + AW'(1)] <= i_push.fin;
            end
        end else if (i_push.end_valid) begin
            r_mem[r_wr] <= i_push.fin;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(cotp_pkg::RQ_DEPTH))
        else $error("result queue overflow");

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.prim_valid || i_push.end_valid) |-> r_count <= CW'(cotp_pkg::RQ_DEPTH - 2))
        else $error("result pushed without room for two");

    a_double_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.prim_valid && i_push.end_valid && !pop_ok)
        |=> r_count == $past(r_count) + CW'(2))
        else $error("double push lost an entry");

endmodule

// ===== test/cotp_result_check.sv =====
`timescale 1ns / 100ps

// watches both streams, predicts the results of every accepted byte and compares
module cotp_result_check (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [7:0]   i_s_tdata,   // [7:0] data_byte
    input  logic         i_s_tlast,   // block_end
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [191:0] i_m_tdata,   // raw_type, byte_a, byte_b, byte_c,
                                      // word_0, word_1, word_2, word_3, word_4
    input  logic [1:0]   i_m_tuser,   // [1:0] event_res
    input  logic         i_m_tlast,   // run_last
    output int           o_mismatches,
    output int           o_pending,
    output int           o_options,
    output int           o_unknowns,
    output int           o_dones,
    output int           o_truncs
);

    cotp_pkg::t_result expected_results[$];

    // parser state as the block should hold it
    cotp_pkg::t_phase phase;
    logic [7:0] opt_type;
    logic [7:0] opt_len;
    logic [7:0] got_bytes;
    logic       discarding;
    logic [7:0] payload [cotp_pkg::MAX_OPTION_PAYLOAD_DEF];

    function automatic logic [7:0] fixed_len(input logic [7:0] t);
        case (t)
            cotp_pkg::OPT_MTU:   return cotp_pkg::SZ_MTU;
            cotp_pkg::OPT_FLUSH: return cotp_pkg::SZ_FLUSH;
            cotp_pkg::OPT_QOS:   return cotp_pkg::SZ_QOS;
            cotp_pkg::OPT_RFC:   return cotp_pkg::SZ_RFC;
            cotp_pkg::OPT_FCS:   return cotp_pkg::SZ_FCS;
            cotp_pkg::OPT_EFS:   return cotp_pkg::SZ_EFS;
            cotp_pkg::OPT_EWS:   return cotp_pkg::SZ_EWS;
            default:             return 8'd0;
        endcase
    endfunction

    // little-endian field out of the payload
    function automatic logic [31:0] le_field(input int off, input int nbytes);
        logic [31:0] v;
        v = '0;
        for (int k = 0; k < nbytes; k++) begin
            v |= 32'(payload[off + k]) << (8 * k);
        end
        return v;
    endfunction

    function automatic cotp_pkg::t_result decoded_option();
        cotp_pkg::t_result r;
        r = '0;
        r.event_res = cotp_pkg::EV_OPTION;
        r.raw_type  = opt_type;
        case (opt_type)
            cotp_pkg::OPT_MTU, cotp_pkg::OPT_FLUSH, cotp_pkg::OPT_EWS: begin
                r.word_0 = le_field(0, 2);
            end
            cotp_pkg::OPT_QOS: begin
                // first byte carries flags and is not reported
                r.byte_a = payload[1];
                r.word_0 = le_field(2, 4);
                r.word_1 = le_field(6, 4);
                r.word_2 = le_field(10, 4);
                r.word_3 = le_field(14, 4);
                r.word_4 = le_field(18, 4);
            end
            cotp_pkg::OPT_RFC: begin
                r.byte_a = payload[0];
                r.byte_b = payload[1];
                r.byte_c = payload[2];
                r.word_0 = le_field(3, 2);
                r.word_1 = le_field(5, 2);
                r.word_2 = le_field(7, 2);
            end
            cotp_pkg::OPT_FCS: begin
                r.byte_a = payload[0];
            end
            cotp_pkg::OPT_EFS: begin
                r.byte_a = payload[0];
                r.byte_b = payload[1];
                r.word_0 = le_field(2, 2);
                r.word_1 = le_field(4, 4);
                r.word_2 = le_field(8, 4);
                r.word_3 = le_field(12, 4);
            end
            default: ;
        endcase
        return r;
    endfunction

    // advance the parser by one byte and queue what it should produce
    function automatic void parse_byte(input logic [7:0] b, input logic last);
        cotp_pkg::t_result res [2];
        int         n;
        logic [7:0] size;
        n = 0;
        res[0] = '0;
        res[1] = '0;
        if (!discarding) begin
            case (phase)
                cotp_pkg::PH_TYPE: begin
                    opt_type = b;
                    phase    = cotp_pkg::PH_LEN;
                end
                cotp_pkg::PH_LEN: begin
                    opt_len   = b;
                    got_bytes = 8'd0;
                    size      = fixed_len(opt_type);
                    if (size == 8'd0) begin
                        res[n].event_res = cotp_pkg::EV_UNKNOWN;
                        res[n].raw_type  = opt_type;
                        n++;
                        phase = (b == 8'd0) ? cotp_pkg::PH_TYPE : cotp_pkg::PH_SKIP;
                    end else if (b != size) begin
                        // wrong length on a known option: drop the rest of the block
                        discarding = 1'b1;
                    end else begin
                        phase = cotp_pkg::PH_DATA;
                    end
                end
                cotp_pkg::PH_DATA: begin
                    if (got_bytes < 8'(cotp_pkg::MAX_OPTION_PAYLOAD_DEF)) begin
                        payload[got_bytes] = b;
                    end
                    got_bytes = got_bytes + 8'd1;
                    if (got_bytes >= opt_len) begin
                        res[n] = decoded_option();
                        n++;
                        phase = cotp_pkg::PH_TYPE;
                    end
                end
                default: begin
                    got_bytes = got_bytes + 8'd1;
                    if (got_bytes >= opt_len) begin
                        phase = cotp_pkg::PH_TYPE;
                    end
                end
            endcase
        end
        if (last) begin
            res[n].event_res = (discarding || phase != cotp_pkg::PH_TYPE)
                               ? cotp_pkg::EV_TRUNC : cotp_pkg::EV_DONE;
            n++;
            phase      = cotp_pkg::PH_TYPE;
            opt_type   = 8'd0;
            opt_len    = 8'd0;
            got_bytes  = 8'd0;
            discarding = 1'b0;
        end
        if (n > 0) begin
            res[n - 1].run_last = 1'b1;
        end
        for (int i = 0; i < n; i++) begin
            expected_results = {expected_results, res[i]};
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] exp_v,
                                   input logic [31:0] got_v);
        $display("%0t ns  MISMATCH %s: expected 0x%0h, got 0x%0h", $time, what, exp_v, got_v);
        o_mismatches++;
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
        if (exp_v !== got_v) begin
            report_mismatch(name, exp_v, got_v);
        end
    endtask

    task automatic compare_result(input cotp_pkg::t_result e, input cotp_pkg::t_result g);
        check_field("event_res", 32'(e.event_res), 32'(g.event_res));
        check_field("raw_type",  32'(e.raw_type),  32'(g.raw_type));
        check_field("byte_a",    32'(e.byte_a),    32'(g.byte_a));
        check_field("byte_b",    32'(e.byte_b),    32'(g.byte_b));
        check_field("byte_c",    32'(e.byte_c),    32'(g.byte_c));
        check_field("word_0",    e.word_0,         g.word_0);
        check_field("word_1",    e.word_1,         g.word_1);
        check_field("word_2",    e.word_2,         g.word_2);
        check_field("word_3",    e.word_3,         g.word_3);
        check_field("word_4",    e.word_4,         g.word_4);
        check_field("run_last",  32'(e.run_last),  32'(g.run_last));
    endtask

    always @(posedge i_clk) begin
        cotp_pkg::t_result got;
        if (!i_rst_n) begin
            phase        = cotp_pkg::PH_TYPE;
            opt_type     = 8'd0;
            opt_len      = 8'd0;
            got_bytes    = 8'd0;
            discarding   = 1'b0;
            o_mismatches = 0;
            o_options    = 0;
            o_unknowns   = 0;
            o_dones      = 0;
            o_truncs     = 0;
            expected_results.delete();
        end else begin
            // results from a byte are registered in the queue before they show up, so the
            // order of the two checks within an edge does not matter
            if (i_m_tvalid && i_m_tready) begin
                got.event_res = i_m_tuser;
                got.raw_type  = i_m_tdata[7:0];
                got.byte_a    = i_m_tdata[15:8];
                got.byte_b    = i_m_tdata[23:16];
                got.byte_c    = i_m_tdata[31:24];
                got.word_0    = i_m_tdata[63:32];
                got.word_1    = i_m_tdata[95:64];
                got.word_2    = i_m_tdata[127:96];
                got.word_3    = i_m_tdata[159:128];
                got.word_4    = i_m_tdata[191:160];
                got.run_last  = i_m_tlast;
                case (i_m_tuser)
                    cotp_pkg::EV_OPTION:  o_options++;
                    cotp_pkg::EV_UNKNOWN: o_unknowns++;
                    cotp_pkg::EV_DONE:    o_dones++;
                    default:              o_truncs++;
                endcase
                if (expected_results.size() == 0) begin
                    report_mismatch("result word with nothing pending", 32'd0,
                                    32'(i_m_tuser));
                end else begin
                    compare_result(expected_results.pop_front(), got);
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                parse_byte(i_s_tdata, i_s_tlast);
            end
        end
        o_pending = expected_results.size();
    end

endmodule

// ===== test/config_option_tlv_parser_tb.sv =====
`timescale 1ns / 100ps

module config_option_tlv_parser_tb;

    localparam int RANDOM_BYTES = 1850;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int LONG_HOLD    = 300;    // receiver hold-off, in cycles
    localparam int DRAIN_CYCLES = 20;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_tvalid;
    logic         o_s_tready;
    logic [7:0]   i_s_tdata;   // [7:0] data_byte
    logic         i_s_tlast;   // block_end
    logic         o_m_tvalid;
    logic         i_m_tready;
    logic [191:0] o_m_tdata;   // raw_type, byte_a, byte_b, byte_c,
                               // word_0, word_1, word_2, word_3, word_4
    logic [1:0]   o_m_tuser;   // [1:0] event_res
    logic         o_m_tlast;   // run_last

    int mismatches, pending, n_options, n_unknowns, n_dones, n_truncs;

    int         cycle_count   = 0;
    int         bytes_sent    = 0;
    int         blocks_sent   = 0;
    int         burst_left    = 0;
    logic       long_hold_go  = 1'b0;
    logic [7:0] block_bytes[$];

    config_option_tlv_parser uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    cotp_result_check u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tlast    (i_s_tlast),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tuser    (o_m_tuser),
        .i_m_tlast    (o_m_tlast),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_options    (n_options),
        .o_unknowns   (n_unknowns),
        .o_dones      (n_dones),
        .o_truncs     (n_truncs)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still pending", cycle_count, pending);
            $display("Regression FAIL");
            $finish;
        end
    end

    // receiver: segments of always ready, random stalls or mostly stalled,
    // plus one long hold-off once the sender asks for it
    initial begin
        int   seg_left;
        int   mode;
        logic held;
        seg_left = 0;
        mode     = 0;
        held     = 1'b0;
        i_m_tready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold_go && !held) begin
                held = 1'b1;
                i_m_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
            end else begin
                if (seg_left == 0) begin
                    mode     = $urandom_range(0, 2);
                    seg_left = $urandom_range(10, 80);
                end
                seg_left--;
                case (mode)
                    0:       i_m_tready <= 1'b1;
                    1:       i_m_tready <= 1'($urandom_range(0, 1));
                    default: i_m_tready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    // offer one byte and hold it until taken; bursts of random length with random gaps, sometimes none, between
    task automatic push_byte(input logic [7:0] b, input logic last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        @(negedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_block();
        for (int i = 0; i < block_bytes.size(); i++) begin
            push_byte(block_bytes[i], i == block_bytes.size() - 1);
        end
        blocks_sent++;
    endtask

    // add one byte at the tail of the block being built
    function automatic void add_byte(input logic [7:0] b);
        block_bytes = {block_bytes, b};
    endfunction

    // payload content leaning on the all-zero and all-one extremes
    function automatic logic [7:0] payload_byte();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return 8'h00;
        if (roll == 1) return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] known_size(input logic [7:0] t);
        case (t)
            cotp_pkg::OPT_MTU:   return cotp_pkg::SZ_MTU;
            cotp_pkg::OPT_FLUSH: return cotp_pkg::SZ_FLUSH;
            cotp_pkg::OPT_QOS:   return cotp_pkg::SZ_QOS;
            cotp_pkg::OPT_RFC:   return cotp_pkg::SZ_RFC;
            cotp_pkg::OPT_FCS:   return cotp_pkg::SZ_FCS;
            cotp_pkg::OPT_EFS:   return cotp_pkg::SZ_EFS;
            default:             return cotp_pkg::SZ_EWS;
        endcase
    endfunction

    // mostly well-formed blocks; some unknown options, wrong lengths and cut-off ends
    task automatic build_random_block();
        int         n_opts;
        int         roll;
        int         cut;
        logic [7:0] t;
        logic [7:0] len;
        block_bytes.delete();
        n_opts = $urandom_range(0, 4);
        for (int i = 0; i < n_opts; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 75) begin
                t   = 8'($urandom_range(1, 7));
                len = known_size(t);
            end else if (roll < 88) begin
                // unknown type, including zero and the hint-bit range
                t   = ($urandom_range(0, 4) == 0) ? 8'h00 : 8'($urandom_range(8, 255));
                len = 8'($urandom_range(0, 6));
            end else begin
                t = 8'($urandom_range(1, 7));
                do len = 8'($urandom_range(0, 255)); while (len == known_size(t));
            end
            add_byte(t);
            add_byte(len);
            // after a wrong length the tail is ignored anyway, keep it short
            if (roll >= 88) len = 8'($urandom_range(0, 3));
            for (int k = 0; k < len; k++) begin
                add_byte(payload_byte());
            end
        end
        if (block_bytes.size() == 0) begin
            add_byte(payload_byte());
        end else if (block_bytes.size() > 1 && $urandom_range(0, 9) == 0) begin
            cut = $urandom_range(1, block_bytes.size() - 1);
            while (block_bytes.size() > cut) void'(block_bytes.pop_back());
        end
    endtask

    task automatic wait_all_results();
        i_s_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
    endtask

    initial begin
        int  directed_bytes;
        logic paused;
        paused = 1'b0;
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= 8'h00;
        i_s_tlast  <= 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: extremes, special endings and the odd type codes
        block_bytes = '{cotp_pkg::OPT_MTU, cotp_pkg::SZ_MTU, 8'hFF, 8'hFF};  // option, done
        send_block();
        block_bytes = '{cotp_pkg::OPT_FLUSH, cotp_pkg::SZ_FLUSH, 8'h00, 8'h00};
        send_block();
        block_bytes = '{8'h80, 8'h00};                         // hint bit, empty unknown
        send_block();
        block_bytes = '{8'hFF, 8'h03};                         // unknown, end right after its length
        send_block();
        block_bytes = '{cotp_pkg::OPT_MTU, 8'h03, 8'h55};      // wrong length
        send_block();
        block_bytes = '{cotp_pkg::OPT_FLUSH};                  // end inside the header
        send_block();
        block_bytes = '{cotp_pkg::OPT_EWS, cotp_pkg::SZ_EWS, 8'hA5};  // end inside payload
        send_block();
        block_bytes = '{cotp_pkg::OPT_FCS, cotp_pkg::SZ_FCS, 8'h5A};
        send_block();
        block_bytes = '{8'h00, 8'h01, 8'hFF};                  // type zero, skipped payload
        send_block();
        directed_bytes = bytes_sent;

        while (bytes_sent < directed_bytes + RANDOM_BYTES) begin
            // long receiver hold-off while bytes keep coming, so the queue fills
            if (bytes_sent >= directed_bytes + 400) long_hold_go = 1'b1;
            // and one pause until everything has drained
            if (!paused && bytes_sent >= directed_bytes + 1000) begin
                paused = 1'b1;
                wait_all_results();
            end
            build_random_block();
            send_block();
        end

        wait_all_results();
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("sent %0d bytes in %0d blocks (%0d directed bytes), in %0d cycles",
                 bytes_sent, blocks_sent, directed_bytes, cycle_count);
        $display("results seen: %0d options, %0d unknown, %0d done, %0d truncated",
                 n_options, n_unknowns, n_dones, n_truncs);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
